// ----- hdl/ust_pkg.sv -----
// Shared types and constants for the UART serial transmitter.
// Word layouts, opcode, parity, register index and frame state codes.
// No dependencies.
`default_nettype none

package ust_pkg;

  localparam int unsigned DATA_W = 9;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] data;
  } ust_in_t;

  typedef struct packed {
    logic tx_level;
    logic busy_res;
    logic send_status;
    logic done_res;
  } ust_out_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [2:0] PAR_NONE  = 3'd0;
  localparam logic [2:0] PAR_ODD   = 3'd1;
  localparam logic [2:0] PAR_MARK  = 3'd3;
  localparam logic [2:0] PAR_SPACE = 3'd4;

  localparam logic [1:0] REG_BIT_PERIOD  = 2'd0;
  localparam logic [1:0] REG_CHAR_BITS   = 2'd1;
  localparam logic [1:0] REG_PARITY_MODE = 2'd2;
  localparam logic [1:0] REG_STOP_BITS   = 2'd3;

  localparam logic [15:0] RST_BIT_PERIOD  = 16'd625;
  localparam logic [3:0]  RST_CHAR_BITS   = 4'd8;
  localparam logic [2:0]  RST_PARITY_MODE = 3'd0;
  localparam logic [1:0]  RST_STOP_BITS   = 2'd1;

  localparam logic [5:0] MIN_CHAR_BITS = 6'd5;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_GUARD  = 7'b0000010,
    ST_DATA   = 7'b0000100,
    ST_PARITY = 7'b0001000,
    ST_STOP1  = 7'b0010000,
    ST_STOP2  = 7'b0100000,
    ST_END    = 7'b1000000
  } ust_state_e;

endpackage

`default_nettype wire

// ----- hdl/uart_serial_transmitter_core.sv -----
// UART serial transmitter core: framing state, bit timer and result register.
// Depends on ust_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries one word per
//   timer tick (opcode tick) or send request (opcode send, data = character).
//   Output channel (out_valid_o / out_stall_i / out_word_o) returns one word
//   per input word: line level, busy, send rejected, done.
//   Result: registered, valid in the cycle after the input word is accepted.
//   Throughput: one word per cycle unless stalled (see below); the framing
//   state and bit timer update in the same cycle the word is taken, and the
//   result register is refilled while its previous contents are being taken.
//   Stall: when a result is held and out_stall_i is high, in_stall_o is high
//   and all state holds.
//   Config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes the register named
//   by cfg_idx_i; write only while the block is idle.
//   Reset: idle, line high, registers at defaults (period 625, 8 data bits,
//   no parity, one stop bit), no result pending.
`default_nettype none

module uart_serial_transmitter_core
  import ust_pkg::*;
#(
  parameter int unsigned MAX_BITS     = 9,
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire ust_in_t     in_word_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      ust_out_t    out_word_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam logic [31:0] PERIOD_LIM =
    (PERIOD_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PERIOD_WIDTH) - 32'd1);
  localparam logic [5:0] MAX_BITS_C = 6'(MAX_BITS);

  logic [15:0] bit_period_q;
  logic [3:0]  char_bits_q;
  logic [2:0]  parity_mode_q;
  logic [1:0]  stop_bits_q;

  ust_state_e              state_q, state_d;
  logic [3:0]              bit_idx_q, bit_idx_d;
  logic [MAX_BITS-1:0]     held_q, held_d;
  logic [PERIOD_WIDTH-1:0] tick_q, tick_d;
  logic                    line_q, line_d;

  logic     out_valid_q;
  ust_out_t out_q, out_d;

  logic in_acc;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // effective period and character length
  logic [31:0]             bp_ext;
  logic [PERIOD_WIDTH-1:0] eff_period;
  logic [5:0]              eff_bits;
  always_comb begin
    bp_ext = 32'(bit_period_q);
    if (bp_ext == 32'd0) begin
      eff_period = PERIOD_WIDTH'(1);
    end else if (bp_ext > PERIOD_LIM) begin
      eff_period = PERIOD_LIM[PERIOD_WIDTH-1:0];
    end else begin
      eff_period = bp_ext[PERIOD_WIDTH-1:0];
    end
    eff_bits = 6'(char_bits_q);
    if (eff_bits < MIN_CHAR_BITS) eff_bits = MIN_CHAR_BITS;
    if (eff_bits > MAX_BITS_C) eff_bits = MAX_BITS_C;
  end

  // parity over transmitted data bits only
  logic parity;
  always_comb begin
    parity = 1'b0;
    for (int i = 0; i < MAX_BITS; i++) begin
      if (6'(i) < eff_bits) parity = parity ^ held_q[i];
    end
  end

  logic [MAX_BITS+DATA_W-1:0] data_ext;
  logic [PERIOD_WIDTH-1:0]    tick_inc;
  logic [MAX_BITS-1:0]        held_sh;
  logic [4:0]                 bit_idx_inc;
  logic                       rejected, done;

  assign data_ext    = {{MAX_BITS{1'b0}}, in_word_i.data};
  assign tick_inc    = tick_q + PERIOD_WIDTH'(1);
  assign held_sh     = held_q >> bit_idx_q;
  assign bit_idx_inc = 5'(bit_idx_q) + 5'd1;

  always_comb begin
    state_d   = state_q;
    bit_idx_d = bit_idx_q;
    held_d    = held_q;
    tick_d    = tick_q;
    line_d    = line_q;
    rejected  = 1'b0;
    done      = 1'b0;
    if (in_word_i.opcode == OP_SEND) begin
      if (state_q == ST_IDLE) begin
        held_d    = data_ext[MAX_BITS-1:0];
        bit_idx_d = 4'd0;
        tick_d    = '0;
        state_d   = ST_GUARD;
      end else begin
        rejected = 1'b1;
      end
    end else if (state_q != ST_IDLE) begin
      tick_d = tick_inc;
      if (tick_inc >= eff_period) begin
        tick_d = '0;
        unique case (state_q)
          ST_GUARD: begin
            line_d    = 1'b0;
            bit_idx_d = 4'd0;
            state_d   = ST_DATA;
          end
          ST_DATA: begin
            line_d    = held_sh[0];
            bit_idx_d = bit_idx_inc[3:0];
            if (6'(bit_idx_inc) >= eff_bits) begin
              state_d = (parity_mode_q == PAR_NONE) ? ST_STOP1 : ST_PARITY;
            end
          end
          ST_PARITY: begin
            priority if (parity_mode_q == PAR_ODD) line_d = ~parity;
            else if (parity_mode_q == PAR_MARK) line_d = 1'b1;
            else if (parity_mode_q == PAR_SPACE) line_d = 1'b0;
            else line_d = parity;
            state_d = ST_STOP1;
          end
          ST_STOP1: begin
            line_d  = 1'b1;
            state_d = (stop_bits_q >= 2'd2) ? ST_STOP2 : ST_END;
          end
          ST_STOP2: begin
            line_d  = 1'b1;
            state_d = ST_END;
          end
          ST_END: begin
            line_d  = 1'b1;
            state_d = ST_IDLE;
            done    = 1'b1;
          end
          default: begin
            line_d  = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end
    end
    out_d.tx_level    = line_d;
    out_d.busy_res    = (state_d != ST_IDLE);
    out_d.send_status = rejected;
    out_d.done_res    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  <= RST_BIT_PERIOD;
      char_bits_q   <= RST_CHAR_BITS;
      parity_mode_q <= RST_PARITY_MODE;
      stop_bits_q   <= RST_STOP_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIT_PERIOD:  bit_period_q  <= cfg_data_i;
        REG_CHAR_BITS:   char_bits_q   <= cfg_data_i[3:0];
        REG_PARITY_MODE: parity_mode_q <= cfg_data_i[2:0];
        REG_STOP_BITS:   stop_bits_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_idx_q   <= 4'd0;
      held_q      <= '0;
      tick_q      <= '0;
      line_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q   <= state_d;
        bit_idx_q <= bit_idx_d;
        held_q    <= held_d;
        tick_q    <= tick_d;
        line_q    <= line_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_send_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.opcode == OP_SEND && state_q == ST_IDLE) |=> state_q == ST_GUARD)
    else $error("accepted send did not start a frame");

  a_low_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !line_q |-> state_q != ST_IDLE)
    else $error("line low while idle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> !out_q.busy_res)
    else $error("done with busy still set");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.send_status) |-> out_q.busy_res)
    else $error("send rejected while idle");

endmodule

`default_nettype wire

// ----- test/ust_line_checker.sv -----
// Line checker for the UART serial transmitter: predicts one result word per
// accepted input word and compares it with the words taken from the block.
// Depends on ust_pkg.
`timescale 1ns / 100ps

module ust_line_checker
  import ust_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  ust_in_t     in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  ust_out_t    out_word_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic        line_busy_o
);

  logic [15:0] period_q;
  logic [3:0]  char_bits_q;
  logic [2:0]  parity_q;
  logic [1:0]  stop_q;

  ust_state_e  frame_st;
  logic [4:0]  bit_pos;
  logic [8:0]  held_char;
  logic [15:0] tick_cnt;
  logic        line_lvl;

  ust_out_t    line_words_due[$];
  ust_out_t    want;
  int          mismatches = 0;

  // One bit time elapsed; returns 1 when the frame ends.
  function automatic logic line_bit_event(int unsigned n);
    logic p;
    p = ^(held_char & (9'h1FF >> (DATA_W - n)));
    case (frame_st)
      ST_GUARD: begin
        line_lvl = 1'b0;
        bit_pos  = '0;
        frame_st = ST_DATA;
      end
      ST_DATA: begin
        line_lvl = held_char[bit_pos];
        bit_pos  = bit_pos + 5'd1;
        if (bit_pos >= n) begin
          frame_st = (parity_q == PAR_NONE) ? ST_STOP1 : ST_PARITY;
        end
      end
      ST_PARITY: begin
        case (parity_q)
          PAR_ODD:   line_lvl = ~p;
          PAR_MARK:  line_lvl = 1'b1;
          PAR_SPACE: line_lvl = 1'b0;
          default:   line_lvl = p;
        endcase
        frame_st = ST_STOP1;
      end
      ST_STOP1: begin
        line_lvl = 1'b1;
        frame_st = (stop_q >= 2'd2) ? ST_STOP2 : ST_END;
      end
      ST_STOP2: begin
        line_lvl = 1'b1;
        frame_st = ST_END;
      end
      ST_END: begin
        line_lvl = 1'b1;
        frame_st = ST_IDLE;
        return 1'b1;
      end
      default: begin
        line_lvl = 1'b1;
        frame_st = ST_IDLE;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic ust_out_t tx_line_step(ust_in_t w);
    ust_out_t    r;
    int unsigned n;
    logic [15:0] per;
    r   = '0;
    n   = (char_bits_q < 4'd5) ? 5 : (char_bits_q > DATA_W) ? DATA_W : char_bits_q;
    per = (period_q == '0) ? 16'd1 : period_q;
    if (w.opcode == OP_SEND) begin
      if (frame_st == ST_IDLE) begin
        held_char = w.data;
        bit_pos   = '0;
        tick_cnt  = '0;
        frame_st  = ST_GUARD;
      end else begin
        r.send_status = 1'b1;
      end
    end else if (frame_st != ST_IDLE) begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= per) begin
        tick_cnt   = '0;
        r.done_res = line_bit_event(n);
      end
    end
    r.tx_level = line_lvl;
    r.busy_res = (frame_st != ST_IDLE);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    = RST_BIT_PERIOD;
      char_bits_q = RST_CHAR_BITS;
      parity_q    = RST_PARITY_MODE;
      stop_q      = RST_STOP_BITS;
      frame_st    = ST_IDLE;
      bit_pos     = '0;
      held_char   = '0;
      tick_cnt    = '0;
      line_lvl    = 1'b1;
      line_words_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (line_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word %b", out_word_i);
          end
        end else begin
          want = line_words_due.pop_front();
          if (out_word_i.tx_level !== want.tx_level ||
              out_word_i.busy_res !== want.busy_res ||
              out_word_i.send_status !== want.send_status ||
              out_word_i.done_res !== want.done_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: line/busy/rej/done want %b%b%b%b got %b%b%b%b",
                       want.tx_level, want.busy_res, want.send_status, want.done_res,
                       out_word_i.tx_level, out_word_i.busy_res,
                       out_word_i.send_status, out_word_i.done_res);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BIT_PERIOD:  period_q    = cfg_data_i;
          REG_CHAR_BITS:   char_bits_q = cfg_data_i[3:0];
          REG_PARITY_MODE: parity_q    = cfg_data_i[2:0];
          REG_STOP_BITS:   stop_q      = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        line_words_due.push_back(tx_line_step(in_word_i));
      end
    end
    pending_o   = line_words_due.size();
    line_busy_o = (frame_st != ST_IDLE);
  end

  assign fail_count_o = mismatches;

endmodule

// ----- test/tb_uart_serial_transmitter_core.sv -----
// Testbench top for uart_serial_transmitter_core: clock, reset, register
// setup, tick/send stimulus with random idling, and the verdict.
// Depends on ust_pkg, uart_serial_transmitter_core and ust_line_checker.
`timescale 1ns / 100ps

module tb_uart_serial_transmitter_core;
  import ust_pkg::*;

  localparam logic [2:0] PAR_EVEN     = 3'd2;
  localparam logic [2:0] PAR_UNDEF_LO = 3'd5;
  localparam logic [2:0] PAR_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [15:0] period;
    logic [3:0]  char_bits;
    logic [2:0]  parity;
    logic [1:0]  stop;
  } line_fmt_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  ust_in_t     in_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  ust_out_t    out_word_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  int   fail_total;
  int   words_pending;
  logic line_busy;

  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  bit   rx_fast = 1'b0;
  int   rx_hold_cycles = 0;

  uart_serial_transmitter_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  ust_line_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_total),
    .pending_o    (words_pending),
    .line_busy_o  (line_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // Result side: per-word stall draw, plus a long hold when requested.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        hold = (rx_fast || rx_calm) ? 0 : $urandom_range(17, 0);
      end
      if ($urandom_range(39, 0) == 0) rx_calm = !rx_calm;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  function automatic line_fmt_t fmt(logic [15:0] period, logic [3:0] char_bits,
                                    logic [2:0] parity, logic [1:0] stop);
    line_fmt_t f;
    f.period    = period;
    f.char_bits = char_bits;
    f.parity    = parity;
    f.stop      = stop;
    return f;
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic put_word(logic op, logic [8:0] d, bit hurry);
    ust_in_t w;
    int      gap;
    w.opcode = op;
    w.data   = d;
    gap = (hurry || tx_calm) ? 0 : $urandom_range(17, 0);
    if ($urandom_range(39, 0) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Tick the frame out, then wait for every result word.
  task automatic settle_line();
    rx_fast = 1'b1;
    while (line_busy) put_word(OP_TICK, 9'($urandom), 1'b1);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    rx_fast = 1'b0;
  endtask

  task automatic set_line_format(line_fmt_t f, bit junk);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BIT_PERIOD;
    cfg_data_i <= f.period;
    @(negedge clk_i);
    cfg_idx_i  <= REG_CHAR_BITS;
    cfg_data_i <= {junk ? 12'($urandom) : 12'd0, f.char_bits};
    @(negedge clk_i);
    cfg_idx_i  <= REG_PARITY_MODE;
    cfg_data_i <= {junk ? 13'($urandom) : 13'd0, f.parity};
    @(negedge clk_i);
    cfg_idx_i  <= REG_STOP_BITS;
    cfg_data_i <= {junk ? 14'($urandom) : 14'd0, f.stop};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly complete frames with random characters; some sends while busy
  // and some ticks while idle.
  task automatic random_frames(int count);
    logic op;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (words_pending != 0);
      end
      if (line_busy) op = ($urandom_range(19, 0) == 0) ? OP_SEND : OP_TICK;
      else op = ($urandom_range(9, 0) < 7) ? OP_SEND : OP_TICK;
      put_word(op, 9'($urandom), 1'b0);
    end
  endtask

  task automatic send_and_finish(line_fmt_t f, logic [8:0] c);
    set_line_format(f, 1'b0);
    put_word(OP_SEND, c, 1'b0);
    settle_line();
  endtask

  initial begin
    int wait_cnt;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_BIT_PERIOD;
    cfg_data_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset format: idle tick, accepted send, send while busy, some guard
    // ticks, then a short bit period written mid-frame
    put_word(OP_TICK, 9'h1FF, 1'b0);
    put_word(OP_SEND, 9'h1FF, 1'b0);
    put_word(OP_SEND, 9'h000, 1'b0);
    for (int k = 0; k < 20; k++) put_word(OP_TICK, 9'($urandom), 1'b1);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    set_line_format(fmt(16'd1, RST_CHAR_BITS, RST_PARITY_MODE, RST_STOP_BITS), 1'b0);
    settle_line();

    set_line_format(fmt(16'd1, 4'd9, PAR_ODD, 2'd2), 1'b0);
    put_word(OP_SEND, 9'h000, 1'b0);
    put_word(OP_SEND, 9'h155, 1'b0);
    settle_line();
    put_word(OP_SEND, 9'h0AA, 1'b0);
    settle_line();
    send_and_finish(fmt(16'd0, 4'd0, PAR_EVEN, 2'd0), 9'h155);
    send_and_finish(fmt(16'd2, 4'd15, PAR_MARK, 2'd3), 9'h0AA);
    send_and_finish(fmt(16'd3, 4'd5, PAR_SPACE, 2'd1), 9'h1FF);
    send_and_finish(fmt(16'd1, 4'd4, PAR_UNDEF_LO, 2'd2), 9'h133);
    send_and_finish(fmt(16'd1, 4'd7, PAR_UNDEF_HI, 2'd1), 9'h0CC);
    send_and_finish(fmt(16'd2, 4'd6, PAR_NONE, 2'd0), 9'h1E1);

    for (int ph = 0; ph < 11; ph++) begin
      set_line_format(fmt(16'($urandom_range(6, 0)), 4'($urandom_range(15, 0)),
                          3'($urandom_range(PAR_UNDEF_HI, PAR_NONE)),
                          2'($urandom_range(3, 0))), 1'b1);
      if (ph == 3) begin
        rx_hold_cycles = 150;
        for (int k = 0; k < 40; k++) put_word(OP_TICK, 9'($urandom), 1'b1);
      end
      random_frames(70);
      settle_line();
    end

    // long bit period: run the guard time out to the start bit
    set_line_format(fmt(16'd40, 4'd5, PAR_NONE, 2'd1), 1'b0);
    rx_fast = 1'b1;
    put_word(OP_SEND, 9'h0FF, 1'b1);
    for (int k = 0; k < 45; k++) put_word(OP_TICK, 9'($urandom), 1'b1);
    put_word(OP_SEND, 9'h100, 1'b1);

    in_valid_i <= 1'b0;
    for (wait_cnt = 0; wait_cnt < 2000 && words_pending != 0; wait_cnt++) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
    if (fail_total == 0 && words_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
